/* hw/rtl/a_weighting_gain_defines.svh */
// Assertion macros shared by the A-weighting gain block.
`ifndef A_WEIGHTING_GAIN_DEFINES_SVH
`define A_WEIGHTING_GAIN_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define AGW_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("a_weighting_gain: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define AGW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("a_weighting_gain: next-cycle check failed");

`endif

/* hw/rtl/agw_pkg.sv */
// Widths, constants and types of the A-weighting gain pipeline.
package agw_pkg;

    localparam int MAG_WIDTH  = 32;
    localparam int FREQ_W     = 19;
    localparam int SQ_W       = 2 * FREQ_W;
    localparam int DEN_W      = SQ_W + 1;
    localparam int FRAC_W     = 24;
    localparam int QUO_W      = FRAC_W + 1;
    localparam int DIV_STEPS  = QUO_W;
    localparam int RAD_W      = 2 * FRAC_W;
    localparam int ROOT_W     = FRAC_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SQRT_REM_W = ROOT_W + 2;
    localparam int BOOST_W    = 25;
    localparam int GRAW_W     = FRAC_W + BOOST_W + 1 - 32;
    localparam int GAIN_W     = 19;
    localparam int PROD_W     = MAG_WIDTH + GAIN_W + 1;
    localparam int PIPE_DEPTH = 2 + DIV_STEPS + 1 + SQRT_STEPS + 3;

    // Pole frequencies squared, in Hz^2 / 256.
    localparam logic [DEN_W-1:0] POLE1_SQ = DEN_W'(64'd108636);
    localparam logic [DEN_W-1:0] POLE2_SQ = DEN_W'(64'd2969418);
    localparam logic [DEN_W-1:0] POLE3_SQ = DEN_W'(64'd139391081);
    localparam logic [DEN_W-1:0] POLE4_SQ = DEN_W'(64'd38065570816);

    localparam logic [BOOST_W-1:0] BOOST_Q24    = BOOST_W'(32'd21121264);
    localparam logic [GAIN_W-1:0]  GAIN_MAX_Q16 = GAIN_W'(32'd262144);

    typedef struct packed {
        logic [MAG_WIDTH-1:0] mag;
        logic                 frame_end;
    } side_t;

    typedef struct packed {
        logic [FRAC_W-1:0] a;
        logic [QUO_W-1:0]  c;
    } ac_t;

endpackage

/* hw/rtl/agw_div.sv */
// Pipelined restoring divider: one quotient bit per stage, num < den or num == den.
module agw_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [agw_pkg::DEN_W-1:0]   num_in,
    input  logic [agw_pkg::DEN_W-1:0]   den_in,
    output logic [agw_pkg::QUO_W-1:0]   quo_out
);
    import agw_pkg::*;

    logic [DEN_W-1:0] rem_reg [DIV_STEPS];
    logic [DEN_W-1:0] den_reg [DIV_STEPS];
    logic [QUO_W-1:0] quo_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        logic [DEN_W:0]   part;
        logic [DEN_W-1:0] den_cur;
        logic [QUO_W-1:0] quo_cur;
        logic             take;
        logic [DEN_W:0]   diff;

        if (j == 0) begin : g_first
            assign part    = {1'b0, num_in};
            assign den_cur = den_in;
            assign quo_cur = '0;
        end else begin : g_rest
            assign part    = {rem_reg[j-1], 1'b0};
            assign den_cur = den_reg[j-1];
            assign quo_cur = quo_reg[j-1];
        end

        assign take = (part >= {1'b0, den_cur});
        assign diff = part - {1'b0, den_cur};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= take ? diff[DEN_W-1:0] : part[DEN_W-1:0];
                den_reg[j] <= den_cur;
                quo_reg[j] <= {quo_cur[QUO_W-2:0], take};
            end
        end
    end

    assign quo_out = quo_reg[DIV_STEPS-1];

endmodule

/* hw/rtl/agw_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
module agw_sqrt (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [agw_pkg::RAD_W-1:0]   rad_in,
    output logic [agw_pkg::ROOT_W-1:0]  root_out
);
    import agw_pkg::*;

    logic [SQRT_REM_W-1:0] rem_reg  [SQRT_STEPS];
    logic [ROOT_W-1:0]     root_reg [SQRT_STEPS];
    logic [RAD_W-1:0]      rad_reg  [SQRT_STEPS];

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
        logic [SQRT_REM_W-1:0] rem_prev;
        logic [ROOT_W-1:0]     root_prev;
        logic [RAD_W-1:0]      rad_prev;
        logic [SQRT_REM_W+1:0] cur;
        logic [SQRT_REM_W+1:0] trial;
        logic [SQRT_REM_W+1:0] diff;
        logic                  take;

        if (i == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad_in;
        end else begin : g_rest
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign rad_prev  = rad_reg[i-1];
        end

        // Bring down the next pair of radicand bits and try root*4 + 1.
        assign cur   = {rem_prev, rad_prev[RAD_W-1 -: 2]};
        assign trial = {2'b00, root_prev, 2'b01};
        assign take  = (cur >= trial);
        assign diff  = cur - trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= take ? diff[SQRT_REM_W-1:0] : cur[SQRT_REM_W-1:0];
                root_reg[i] <= {root_prev[ROOT_W-2:0], take};
                rad_reg[i]  <= {rad_prev[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign root_out = root_reg[SQRT_STEPS-1];

endmodule

/* hw/rtl/a_weighting_gain.sv */
// A-weighting gain top level: per-bin gain computation and output register.
//
// Usage: spectrum bins arrive on the s_ channel (valid/ready), one word per
// bin with its Q15.4 centre frequency, Q16.16 magnitude and end-of-frame mark.
// Each word yields one word on the m_ channel: the magnitude scaled by the
// A-weighting gain (raised by 2 dB, clamped to 4.0), rounded and saturated.
// The frame-end mark travels alongside unchanged.
// Throughput is one word per cycle while m_ready does not stall the output.
// A word passes the squaring and denominator stages, the 25-stage quotient
// pipeline, the 24-stage square root pipeline and the product and output stages.
// The whole pipeline advances together: when the receiver holds m_ready low
// with a word waiting, every stage freezes and s_ready drops, so nothing is
// lost or repeated. Words are taken again in the cycle the output is drained.
// Reset (aresetn low, synchronous) clears all valid bits; words in flight are
// discarded and the block is ready immediately afterwards.
`include "a_weighting_gain_defines.svh"

module a_weighting_gain (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [agw_pkg::FREQ_W-1:0]      s_bin_frequency,
    input  logic [agw_pkg::MAG_WIDTH-1:0]   s_bin_magnitude,
    input  logic                            s_frame_end,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [agw_pkg::MAG_WIDTH-1:0]   m_weighted_magnitude,
    output logic                            m_frame_end_out
);
    import agw_pkg::*;

    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;
    side_t                 side_reg [PIPE_DEPTH];
    logic                  m_valid_reg;
    logic [MAG_WIDTH-1:0]  m_mag_reg;
    logic                  m_fe_reg;

    logic [SQ_W-1:0]   sq_reg;
    logic [DEN_W-1:0]  num_reg;
    logic [DEN_W-1:0]  d1_reg, d2_reg, d3_reg, d4_reg;
    logic [QUO_W-1:0]  qa, qr2, qr3, qc;
    logic [RAD_W-1:0]  rad_reg;
    ac_t               ac_reg;
    ac_t               ac_line_reg [SQRT_STEPS];
    logic [ROOT_W-1:0] root;
    logic [FRAC_W-1:0] ab_reg;
    logic [QUO_W-1:0]  c_reg;
    logic [FRAC_W-1:0] w_reg;
    logic [GAIN_W-1:0] g_reg;

    logic [2*FRAC_W-1:0]        ab_full;
    logic [FRAC_W+QUO_W-1:0]    w_full;
    logic [FRAC_W+BOOST_W:0]    g_full;
    logic [GRAW_W-1:0]          g_raw;
    logic [PROD_W-1:0]          out_full;
    logic [PROD_W-17:0]         out_round;
    side_t                      side_in;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign side_in.mag       = s_bin_magnitude;
    assign side_in.frame_end = s_frame_end;

    // Valid bits and the magnitude / frame mark move with every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[PIPE_DEPTH-2:0], s_valid};
            m_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Square of the frequency, then the four denominators.
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg  <= SQ_W'(s_bin_frequency) * SQ_W'(s_bin_frequency);
            num_reg <= DEN_W'(sq_reg);
            d1_reg  <= DEN_W'(sq_reg) + POLE1_SQ;
            d2_reg  <= DEN_W'(sq_reg) + POLE2_SQ;
            d3_reg  <= DEN_W'(sq_reg) + POLE3_SQ;
            d4_reg  <= DEN_W'(sq_reg) + POLE4_SQ;
        end
    end

    agw_div u_div_a  (.aclk(aclk), .en(en), .num_in(num_reg),  .den_in(d1_reg), .quo_out(qa));
    agw_div u_div_r2 (.aclk(aclk), .en(en), .num_in(num_reg),  .den_in(d2_reg), .quo_out(qr2));
    agw_div u_div_r3 (.aclk(aclk), .en(en), .num_in(num_reg),  .den_in(d3_reg), .quo_out(qr3));
    agw_div u_div_c  (.aclk(aclk), .en(en), .num_in(POLE4_SQ), .den_in(d4_reg), .quo_out(qc));

    // Only the high-pole fraction can reach exactly one; the others stay below it.
    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= RAD_W'(qr2[FRAC_W-1:0]) * RAD_W'(qr3[FRAC_W-1:0]);
            ac_reg.a <= qa[FRAC_W-1:0];
            ac_reg.c <= qc;
            ac_line_reg[0] <= ac_reg;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                ac_line_reg[k] <= ac_line_reg[k-1];
            end
        end
    end

    agw_sqrt u_sqrt (.aclk(aclk), .en(en), .rad_in(rad_reg), .root_out(root));

    assign ab_full = (2*FRAC_W)'(ac_line_reg[SQRT_STEPS-1].a) * (2*FRAC_W)'(root);
    assign w_full  = (FRAC_W+QUO_W)'(ab_reg) * (FRAC_W+QUO_W)'(c_reg);
    assign g_full  = (FRAC_W+BOOST_W+1)'(w_reg) * (FRAC_W+BOOST_W+1)'(BOOST_Q24)
                     + (FRAC_W+BOOST_W+1)'(64'h8000_0000);
    assign g_raw   = g_full[FRAC_W+BOOST_W -: GRAW_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            ab_reg <= ab_full[2*FRAC_W-1:FRAC_W];
            c_reg  <= ac_line_reg[SQRT_STEPS-1].c;
            w_reg  <= w_full[2*FRAC_W-1:FRAC_W];
            g_reg  <= (GAIN_W'(g_raw) > GAIN_MAX_Q16) ? GAIN_MAX_Q16 : GAIN_W'(g_raw);
        end
    end

    assign out_full  = PROD_W'(side_reg[PIPE_DEPTH-1].mag) * PROD_W'(g_reg)
                       + PROD_W'(32'h8000);
    assign out_round = out_full[PROD_W-1:16];

    always_ff @(posedge aclk) begin
        if (en) begin
            m_mag_reg <= (out_round[PROD_W-17:MAG_WIDTH] != '0) ? '1
                         : out_round[MAG_WIDTH-1:0];
            m_fe_reg  <= side_reg[PIPE_DEPTH-1].frame_end;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_weighted_magnitude = m_mag_reg;
    assign m_frame_end_out      = m_fe_reg;

    `AGW_ASSERT_NEXT(a_last_stage_reaches_out, aclk, aresetn, vld_reg[PIPE_DEPTH-1] && en, m_valid_reg)
    `AGW_ASSERT_NEXT(a_stall_freezes_pipe, aclk, aresetn, !en, $stable(vld_reg))
    `AGW_ASSERT_NOW(a_gain_clamped, aclk, aresetn, vld_reg[PIPE_DEPTH-1], g_reg <= GAIN_MAX_Q16)

endmodule

/* tb/sv/a_weighting_gain_tb.sv */
// Self-checking testbench for the A-weighting gain block, with an in-bench gain predictor.
module a_weighting_gain_tb;
    import agw_pkg::*;

    typedef struct {
        logic [FREQ_W-1:0]    freq;
        logic [MAG_WIDTH-1:0] mag;
        logic                 fe;
    } bin_t;

    typedef struct {
        logic [MAG_WIDTH-1:0] wmag;
        logic                 fe;
    } wbin_t;

    localparam int LATENCY   = 56;
    localparam int STALL_MAX = 4000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [FREQ_W-1:0]    s_bin_frequency;
    logic [MAG_WIDTH-1:0] s_bin_magnitude;
    logic                 s_frame_end;
    logic                 m_valid;
    logic                 m_ready;
    logic [MAG_WIDTH-1:0] m_weighted_magnitude;
    logic                 m_frame_end_out;

    bin_t  pending_bins[$];
    wbin_t expected_bins[$];
    int    mismatches;
    int    stall_cycles;
    int    src_idle;
    int    sink_idle;
    bit    idling_on;
    bit    hold_source;
    bit    stim_done;

    a_weighting_gain i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_bin_frequency      (s_bin_frequency),
        .s_bin_magnitude      (s_bin_magnitude),
        .s_frame_end          (s_frame_end),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_weighted_magnitude (m_weighted_magnitude),
        .m_frame_end_out      (m_frame_end_out)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Gain in Q3.16 for a Q15.4 frequency; every quotient is truncated.
    function automatic logic [63:0] a_gain_q16(input logic [FREQ_W-1:0] freq);
        logic [63:0] sq, a, r2, r3, b, c, w, g;
        sq = 64'(freq) * 64'(freq);
        a  = (sq << 24) / (sq + 64'(POLE1_SQ));
        r2 = (sq << 24) / (sq + 64'(POLE2_SQ));
        r3 = (sq << 24) / (sq + 64'(POLE3_SQ));
        b  = isqrt64(r2 * r3);
        c  = (64'(POLE4_SQ) << 24) / (sq + 64'(POLE4_SQ));
        w  = (((a * b) >> 24) * c) >> 24;
        g  = (w * 64'(BOOST_Q24) + (64'd1 << 31)) >> 32;
        if (g > 64'(GAIN_MAX_Q16)) g = 64'(GAIN_MAX_Q16);
        return g;
    endfunction

    function automatic wbin_t weigh_bin(input bin_t b);
        wbin_t       r;
        logic [63:0] g, prod, top;
        g    = a_gain_q16(b.freq);
        prod = 64'(b.mag[MAG_WIDTH-1:16]) * g
             + ((64'(b.mag[15:0]) * g + 64'h8000) >> 16);
        top  = (64'd1 << MAG_WIDTH) - 1;
        r.wmag = (prod > top) ? top[MAG_WIDTH-1:0] : prod[MAG_WIDTH-1:0];
        r.fe   = b.fe;
        return r;
    endfunction

    task automatic queue_bin(input logic [FREQ_W-1:0] f, input logic [MAG_WIDTH-1:0] m,
                             input logic fe);
        bin_t b;
        b.freq = f;
        b.mag  = m;
        b.fe   = fe;
        pending_bins.push_back(b);
    endtask

    // Driver: presents queued words, with random bursts of idling.
    always @(posedge aclk) begin
        bin_t b;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            src_idle <= 0;
        end else if (!s_valid || s_ready) begin
            if (src_idle > 0) begin
                src_idle <= src_idle - 1;
                s_valid  <= 1'b0;
            end else if (idling_on && $urandom_range(0, 15) == 0) begin
                src_idle <= $urandom_range(1, 17) - 1;
                s_valid  <= 1'b0;
            end else if (!hold_source && pending_bins.size() > 0) begin
                b = pending_bins.pop_front();
                expected_bins.push_back(weigh_bin(b));
                s_valid         <= 1'b1;
                s_bin_frequency <= b.freq;
                s_bin_magnitude <= b.mag;
                s_frame_end     <= b.fe;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result word and drives m_ready stalls.
    always @(posedge aclk) begin
        wbin_t e;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_idle <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bins.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected word: mag %h fe %b", m_weighted_magnitude,
                                 m_frame_end_out);
                end else begin
                    e = expected_bins.pop_front();
                    if (e.wmag !== m_weighted_magnitude || e.fe !== m_frame_end_out) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: mag exp %h got %h, fe exp %b got %b",
                                     e.wmag, m_weighted_magnitude, e.fe, m_frame_end_out);
                    end
                end
            end
            if (sink_idle > 0) begin
                sink_idle <= sink_idle - 1;
                m_ready   <= 1'b0;
            end else if (idling_on && $urandom_range(0, 15) == 0) begin
                sink_idle <= $urandom_range(1, 17) - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [FREQ_W-1:0] f;
        s_valid         = 1'b0;
        s_bin_frequency = '0;
        s_bin_magnitude = '0;
        s_frame_end     = 1'b0;
        m_ready         = 1'b0;
        mismatches      = 0;
        stall_cycles    = 0;
        src_idle        = 0;
        sink_idle       = 0;
        idling_on       = 1'b1;
        hold_source     = 1'b0;
        stim_done       = 1'b0;
        aresetn         = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero frequency, field extremes, pole frequencies and saturation.
        queue_bin('0, '1, 1'b0);
        queue_bin('0, '0, 1'b1);
        queue_bin('1, '1, 1'b1);
        queue_bin('1, '0, 1'b0);
        queue_bin(19'd1, '1, 1'b0);
        queue_bin(19'd330, 32'h0001_0000, 1'b0);
        queue_bin(19'd1723, 32'h0001_0000, 1'b0);
        queue_bin(19'd11806, 32'h0001_0000, 1'b0);
        queue_bin(19'd40000, 32'h0001_0000, 1'b0);
        queue_bin(19'd16000, '1, 1'b1);
        queue_bin(19'd40000, '1, 1'b0);
        queue_bin(19'd48000, 32'hFFFF_0000, 1'b0);
        queue_bin(19'd195104, 32'h0000_FFFF, 1'b1);
        queue_bin(19'h2AAAA, 32'hAAAA_AAAA, 1'b0);
        queue_bin(19'h55555, 32'h5555_5555, 1'b1);
        queue_bin(19'd320000, 32'h8000_0000, 1'b0);
        queue_bin(19'd160, 32'h0000_0001, 1'b0);

        // Pause the sender until every result has drained.
        wait (pending_bins.size() == 0);
        hold_source = 1'b1;
        wait (expected_bins.size() == 0);
        hold_source = 1'b0;

        for (int i = 0; i < 1750; i++) begin
            case ($urandom_range(0, 3))
                0: f = FREQ_W'($urandom_range(0, 524287));
                1: f = FREQ_W'($urandom_range(0, 2000));
                2: f = FREQ_W'($urandom_range(2000, 64000));
                default: f = FREQ_W'($urandom_range(64000, 524287));
            endcase
            queue_bin(f, ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 255)
                                                     : $urandom(),
                      $urandom_range(0, 7) == 0);
            if (i == 1400) begin
                wait (pending_bins.size() == 0);
                idling_on = 1'b0;
            end
        end

        wait (pending_bins.size() == 0 && expected_bins.size() == 0);
        repeat (LATENCY + 8) @(posedge aclk);
        if (mismatches == 0 && expected_bins.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
